/* hdl/ccr_pkg.sv */
// ---------------------------------------------------------------------------
// ccr_pkg: shared types and constants of the circle collision resolver
// Command and status bundles, the multiply operation codes, the result
// selection codes and the output saturation helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccr_pkg;

  // Restitution ratios carry this many fraction bits.
  localparam int RATIO_BITS = 24;
  // Elasticity of one in Q1.16.
  localparam logic [16:0] ELAS_ONE = 17'd65536;

  // Internal signed working word, wide enough for every intermediate.
  typedef logic signed [39:0] wide_t;

  // Multiply operation codes, issued in this order by the controller.
  typedef logic [4:0] mop_t;
  localparam mop_t MOP_NONE = 5'd0;
  localparam mop_t MOP_SQX  = 5'd1;
  localparam mop_t MOP_SQY  = 5'd2;
  localparam mop_t MOP_DDX  = 5'd3;
  localparam mop_t MOP_DDY  = 5'd4;
  localparam mop_t MOP_V1NA = 5'd5;
  localparam mop_t MOP_V1NB = 5'd6;
  localparam mop_t MOP_V2NA = 5'd7;
  localparam mop_t MOP_V2NB = 5'd8;
  localparam mop_t MOP_T1X  = 5'd9;
  localparam mop_t MOP_T1Y  = 5'd10;
  localparam mop_t MOP_T2X  = 5'd11;
  localparam mop_t MOP_T2Y  = 5'd12;
  localparam mop_t MOP_K2   = 5'd13;
  localparam mop_t MOP_K1   = 5'd14;
  localparam mop_t MOP_V1F  = 5'd15;
  localparam mop_t MOP_V2F  = 5'd16;
  localparam mop_t MOP_O1X  = 5'd17;
  localparam mop_t MOP_O1Y  = 5'd18;
  localparam mop_t MOP_O2X  = 5'd19;
  localparam mop_t MOP_O2Y  = 5'd20;

  // Which value the output register is loaded with.
  typedef logic [2:0] emit_t;
  localparam emit_t EMIT_NONE = 3'd0;
  localparam emit_t EMIT_PASS = 3'd1;
  localparam emit_t EMIT_HELD = 3'd2;
  localparam emit_t EMIT_CUR  = 3'd3;
  localparam emit_t EMIT_RES0 = 3'd4;
  localparam emit_t EMIT_RES1 = 3'd5;

  // Destination of a division.
  typedef logic [1:0] dsel_t;
  localparam dsel_t DSEL_NX = 2'd0;
  localparam dsel_t DSEL_NY = 2'd1;
  localparam dsel_t DSEL_R2 = 2'd2;
  localparam dsel_t DSEL_R1 = 2'd3;

  typedef struct packed {
    logic  load_held;
    logic  load_cur;
    logic  do_diff;
    logic  sqrt_start;
    logic  do_chk;
    logic  div_start;
    dsel_t div_sel;
    mop_t  mop;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic no_hit;
  } sts_t;

  // Magnitude of a working word.
  function automatic logic [39:0] mag40(input wide_t v);
    return v[39] ? 40'(-v) : 40'(v);
  endfunction

  // Clamp a working word to 32 bit signed.
  function automatic logic signed [31:0] sat32(input wide_t v);
    if (v > 40'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

/* hdl/ccr_sqrt.sv */
// ---------------------------------------------------------------------------
// ccr_sqrt: iterative integer square root
// Floor square root of a 66 bit radicand, one result bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [65:0] rad_i,
  output logic        done_o,
  output logic [32:0] root_o
);

  logic [65:0] rad_q;
  logic [36:0] rem_q;
  logic [32:0] root_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [36:0] rem_n, trial;
  logic        ge;

  // One digit pair per step: shift in two radicand bits and try the subtract.
  always_comb begin
    rem_n = {rem_q[34:0], rad_q[65:64]};
    trial = {2'b00, root_q, 2'b01};
    ge    = rem_n >= trial;
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  // Partial remainder and root.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[63:0], 2'b00};
      rem_q  <= ge ? rem_n - trial : rem_n;
      root_q <= {root_q[31:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* hdl/ccr_divider.sv */
// ---------------------------------------------------------------------------
// ccr_divider: iterative restoring divider
// Divides a 60 bit dividend by a 33 bit divisor when the quotient is known
// to fit in top+1 bits; one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [59:0] num_i,
  input  logic [32:0] den_i,
  input  logic [4:0]  top_i,
  output logic        done_o,
  output logic [25:0] quo_o
);

  logic [59:0] rem_q, dsh_q;
  logic [25:0] q_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic        ge;

  assign ge = rem_q >= dsh_q;

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= top_i;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  // Shifted divisor walks down one place per step.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= 60'(den_i) << top_i;
      q_q   <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      q_q   <= {q_q[24:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule

/* hdl/ccr_ctrl.sv */
// ---------------------------------------------------------------------------
// ccr_ctrl: sequencer of the collision resolver
// Owns the input and output handshakes and the held-particle flag, and
// steps the datapath through distance, normal, push-out and impulse.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          second_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  ccr_pkg::sts_t sts_i,
  output ccr_pkg::cmd_t cmd_o
);

  import ccr_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_PASS  = 5'd1;
  localparam logic [4:0] ST_DIFF  = 5'd2;
  localparam logic [4:0] ST_SQX   = 5'd3;
  localparam logic [4:0] ST_SQY   = 5'd4;
  localparam logic [4:0] ST_SQW   = 5'd5;
  localparam logic [4:0] ST_SQST  = 5'd6;
  localparam logic [4:0] ST_SQRUN = 5'd7;
  localparam logic [4:0] ST_CHK   = 5'd8;
  localparam logic [4:0] ST_EMH   = 5'd9;
  localparam logic [4:0] ST_EMC   = 5'd10;
  localparam logic [4:0] ST_DVX   = 5'd11;
  localparam logic [4:0] ST_DVXW  = 5'd12;
  localparam logic [4:0] ST_DVY   = 5'd13;
  localparam logic [4:0] ST_DVYW  = 5'd14;
  localparam logic [4:0] ST_MULA  = 5'd15;
  localparam logic [4:0] ST_DVR2  = 5'd16;
  localparam logic [4:0] ST_DVR2W = 5'd17;
  localparam logic [4:0] ST_MK1   = 5'd18;
  localparam logic [4:0] ST_DVR1  = 5'd19;
  localparam logic [4:0] ST_DVR1W = 5'd20;
  localparam logic [4:0] ST_MULB  = 5'd21;
  localparam logic [4:0] ST_DRAIN = 5'd22;
  localparam logic [4:0] ST_EM0   = 5'd23;
  localparam logic [4:0] ST_EM1   = 5'd24;

  logic [4:0] state_q, state_d;
  logic       hf_q, hf_d;
  logic       out_valid_q, out_valid_d;
  mop_t       mop_q, mop_d;
  logic       out_free;
  cmd_t       cmd;

  // Next state and command decode.
  always_comb begin
    cmd         = '0;
    state_d     = state_q;
    hf_d        = hf_q;
    mop_d       = mop_q;
    out_free    = !out_valid_q || !out_stall_i;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!second_i) begin
            cmd.load_held = 1'b1;
            hf_d          = 1'b1;
          end else begin
            cmd.load_cur = 1'b1;
            if (hf_q) begin
              hf_d    = 1'b0;
              state_d = ST_DIFF;
            end else begin
              state_d = ST_PASS;
            end
          end
        end
      end
      ST_PASS: begin
        if (out_free) begin
          cmd.emit    = EMIT_PASS;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_DIFF: begin
        cmd.do_diff = 1'b1;
        state_d     = ST_SQX;
      end
      ST_SQX: begin
        cmd.mop = MOP_SQX;
        state_d = ST_SQY;
      end
      ST_SQY: begin
        cmd.mop = MOP_SQY;
        state_d = ST_SQW;
      end
      ST_SQW: state_d = ST_SQST;
      ST_SQST: begin
        cmd.sqrt_start = 1'b1;
        state_d        = ST_SQRUN;
      end
      ST_SQRUN: begin
        if (sts_i.sqrt_done) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd.do_chk = 1'b1;
        state_d    = sts_i.no_hit ? ST_EMH : ST_DVX;
      end
      ST_EMH: begin
        if (out_free) begin
          cmd.emit    = EMIT_HELD;
          out_valid_d = 1'b1;
          state_d     = ST_EMC;
        end
      end
      ST_EMC: begin
        if (out_free) begin
          cmd.emit    = EMIT_CUR;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_DVX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_NX;
        state_d       = ST_DVXW;
      end
      ST_DVXW: begin
        if (sts_i.div_done) begin
          state_d = ST_DVY;
        end
      end
      ST_DVY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_NY;
        state_d       = ST_DVYW;
      end
      ST_DVYW: begin
        if (sts_i.div_done) begin
          mop_d   = MOP_DDX;
          state_d = ST_MULA;
        end
      end
      // Push-out, normal and tangential parts, then the first ratio product.
      ST_MULA: begin
        cmd.mop = mop_q;
        if (mop_q == MOP_K2) begin
          state_d = ST_DVR2;
        end else begin
          mop_d = mop_q + 5'd1;
        end
      end
      ST_DVR2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_R2;
        state_d       = ST_DVR2W;
      end
      ST_DVR2W: begin
        if (sts_i.div_done) begin
          state_d = ST_MK1;
        end
      end
      ST_MK1: begin
        cmd.mop = MOP_K1;
        state_d = ST_DVR1;
      end
      ST_DVR1: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_R1;
        state_d       = ST_DVR1W;
      end
      ST_DVR1W: begin
        if (sts_i.div_done) begin
          mop_d   = MOP_V1F;
          state_d = ST_MULB;
        end
      end
      // Velocity exchange and recombination.
      ST_MULB: begin
        cmd.mop = mop_q;
        if (mop_q == MOP_O2Y) begin
          state_d = ST_DRAIN;
        end else begin
          mop_d = mop_q + 5'd1;
        end
      end
      ST_DRAIN: state_d = ST_EM0;
      ST_EM0: begin
        if (out_free) begin
          cmd.emit    = EMIT_RES0;
          out_valid_d = 1'b1;
          state_d     = ST_EM1;
        end
      end
      ST_EM1: begin
        if (out_free) begin
          cmd.emit    = EMIT_RES1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hf_q        <= 1'b0;
      out_valid_q <= 1'b0;
      mop_q       <= MOP_NONE;
    end else begin
      state_q     <= state_d;
      hf_q        <= hf_d;
      out_valid_q <= out_valid_d;
      mop_q       <= mop_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

/* hdl/ccr_datapath.sv */
// ---------------------------------------------------------------------------
// ccr_datapath: arithmetic of the collision resolver
// Particle registers, one shared signed multiplier with a registered
// product, the square root and divider units and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ccr_pkg::cmd_t       cmd_i,
  output ccr_pkg::sts_t       sts_o,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  vel_x_i,
  input  logic signed [31:0]  vel_y_i,
  input  logic [30:0]         radius_i,
  input  logic [16:0]         elasticity_i,
  input  logic [30:0]         mass_i,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic signed [31:0]  vel_x_o,
  output logic signed [31:0]  vel_y_o,
  output logic                touched_o,
  output logic                last_o
);

  import ccr_pkg::*;

  // Particle registers.
  logic signed [31:0] hpx_q, hpy_q, hvx_q, hvy_q, cpx_q, cpy_q, cvx_q, cvy_q;
  logic [30:0]        hr_q, hm_q, cr_q, cm_q;
  logic [16:0]        he_q, ce_q;

  // Intermediates.
  wide_t       dx_q, dy_q, ddx_q, ddy_q, v1n_q, v2n_q, w_q;
  wide_t       t1x_q, t1y_q, t2x_q, t2y_q, v1f_q, v2f_q;
  wide_t       o1x_q, o1y_q, o2x_q, o2y_q;
  logic [65:0] sumsq_q;
  logic [30:0] half_q;
  logic signed [26:0] nx_q, ny_q;
  logic [25:0] r1_q, r2_q;
  dsel_t       dsel_q;

  // Multiplier.
  logic [67:0] prod_q;
  logic        neg_q;
  mop_t        wop_q;
  wide_t       op_a, op_b, res;
  logic [39:0] mag_a, mag_b;
  logic [67:0] shp;
  logic [4:0]  sh;

  // Output register.
  logic signed [31:0] opx_q, opy_q, ovx_q, ovy_q;
  logic               otouch_q, olast_q;

  // Derived values.
  logic [32:0] d;
  logic [31:0] rsum, msum, msum_e;
  logic [30:0] m1, m2;
  logic [16:0] ee;
  logic [25:0] k;
  logic        sqrt_done, div_done;
  logic [25:0] quo;
  logic [59:0] div_num;
  logic [32:0] div_den;
  logic [4:0]  div_top;

  // Restitution, mass sum with the equal-mass fallback, and radius sum.
  always_comb begin
    ee   = (he_q < ce_q) ? he_q : ce_q;
    if (ee > ELAS_ONE) begin
      ee = ELAS_ONE;
    end
    k    = {18'(ee) + 18'(ELAS_ONE), 8'd0};
    msum = 32'(hm_q) + 32'(cm_q);
    if (msum == '0) begin
      m1     = 31'd1;
      m2     = 31'd1;
      msum_e = 32'd2;
    end else begin
      m1     = hm_q;
      m2     = cm_q;
      msum_e = msum;
    end
    rsum = 32'(hr_q) + 32'(cr_q);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mop)
      MOP_SQX:  begin op_a = dx_q;              op_b = dx_q;              end
      MOP_SQY:  begin op_a = dy_q;              op_b = dy_q;              end
      MOP_DDX:  begin op_a = 40'(half_q);       op_b = 40'(nx_q);         end
      MOP_DDY:  begin op_a = 40'(half_q);       op_b = 40'(ny_q);         end
      MOP_V1NA: begin op_a = 40'(hvx_q);        op_b = 40'(nx_q);         end
      MOP_V1NB: begin op_a = 40'(hvy_q);        op_b = 40'(ny_q);         end
      MOP_V2NA: begin op_a = 40'(cvx_q);        op_b = 40'(nx_q);         end
      MOP_V2NB: begin op_a = 40'(cvy_q);        op_b = 40'(ny_q);         end
      MOP_T1X:  begin op_a = v1n_q;             op_b = 40'(nx_q);         end
      MOP_T1Y:  begin op_a = v1n_q;             op_b = 40'(ny_q);         end
      MOP_T2X:  begin op_a = v2n_q;             op_b = 40'(nx_q);         end
      MOP_T2Y:  begin op_a = v2n_q;             op_b = 40'(ny_q);         end
      MOP_K2:   begin op_a = 40'(m2);           op_b = 40'(k);            end
      MOP_K1:   begin op_a = 40'(m1);           op_b = 40'(k);            end
      MOP_V1F:  begin op_a = w_q;               op_b = 40'(r2_q);         end
      MOP_V2F:  begin op_a = w_q;               op_b = 40'(r1_q);         end
      MOP_O1X:  begin op_a = v1f_q;             op_b = 40'(nx_q);         end
      MOP_O1Y:  begin op_a = v1f_q;             op_b = 40'(ny_q);         end
      MOP_O2X:  begin op_a = v2f_q;             op_b = 40'(nx_q);         end
      MOP_O2Y:  begin op_a = v2f_q;             op_b = 40'(ny_q);         end
      default:  begin op_a = '0;                op_b = '0;                end
    endcase
  end

  // Operand magnitudes for the sign-magnitude multiply.
  assign mag_a = mag40(op_a);
  assign mag_b = mag40(op_b);

  // Sign-magnitude product, registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wop_q <= MOP_NONE;
    end else begin
      wop_q <= cmd_i.mop;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 68'(mag_a[34:0]) * 68'(mag_b[32:0]);
    neg_q  <= op_a[39] ^ op_b[39];
  end

  // Scale the product back, truncating toward zero.
  always_comb begin
    sh  = (wop_q == MOP_V1F || wop_q == MOP_V2F) ? 5'(RATIO_BITS) : 5'(FRAC_BITS);
    shp = prod_q >> sh;
    res = neg_q ? -$signed(shp[39:0]) : $signed(shp[39:0]);
  end

  // Division operands.
  always_comb begin
    if (cmd_i.div_sel == DSEL_NX || cmd_i.div_sel == DSEL_NY) begin
      div_num = (cmd_i.div_sel == DSEL_NX) ? 60'(mag40(dx_q)) << FRAC_BITS
                                           : 60'(mag40(dy_q)) << FRAC_BITS;
      div_den = d;
      div_top = 5'(FRAC_BITS);
    end else begin
      div_num = prod_q[59:0];
      div_den = 33'(msum_e);
      div_top = 5'(RATIO_BITS + 1);
    end
  end

  ccr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (sumsq_q),
    .done_o  (sqrt_done),
    .root_o  (d)
  );

  ccr_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .top_i   (div_top),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Particle capture, intermediates and write-back of finished products.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_held) begin
      hpx_q <= pos_x_i;
      hpy_q <= pos_y_i;
      hvx_q <= vel_x_i;
      hvy_q <= vel_y_i;
      hr_q  <= radius_i;
      he_q  <= elasticity_i;
      hm_q  <= mass_i;
    end
    if (cmd_i.load_cur) begin
      cpx_q <= pos_x_i;
      cpy_q <= pos_y_i;
      cvx_q <= vel_x_i;
      cvy_q <= vel_y_i;
      cr_q  <= radius_i;
      ce_q  <= elasticity_i;
      cm_q  <= mass_i;
    end
    if (cmd_i.do_diff) begin
      dx_q <= 40'(cpx_q) - 40'(hpx_q);
      dy_q <= 40'(cpy_q) - 40'(hpy_q);
    end
    if (cmd_i.do_chk) begin
      half_q <= 31'((rsum - d[31:0]) >> 1);
    end
    if (cmd_i.div_start) begin
      dsel_q <= cmd_i.div_sel;
      if (cmd_i.div_sel == DSEL_R2) begin
        w_q <= v2n_q - v1n_q;
      end
    end
    if (div_done) begin
      case (dsel_q)
        DSEL_NX: nx_q <= dx_q[39] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        DSEL_NY: ny_q <= dy_q[39] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        DSEL_R2: r2_q <= quo;
        DSEL_R1: r1_q <= quo;
        default: r1_q <= quo;
      endcase
    end
    case (wop_q)
      MOP_SQX:  sumsq_q <= prod_q[65:0];
      MOP_SQY:  sumsq_q <= sumsq_q + prod_q[65:0];
      MOP_DDX:  ddx_q <= res;
      MOP_DDY:  ddy_q <= res;
      MOP_V1NA: v1n_q <= res;
      MOP_V1NB: v1n_q <= v1n_q + res;
      MOP_V2NA: v2n_q <= res;
      MOP_V2NB: v2n_q <= v2n_q + res;
      MOP_T1X:  t1x_q <= 40'(hvx_q) - res;
      MOP_T1Y:  t1y_q <= 40'(hvy_q) - res;
      MOP_T2X:  t2x_q <= 40'(cvx_q) - res;
      MOP_T2Y:  t2y_q <= 40'(cvy_q) - res;
      MOP_V1F:  v1f_q <= v1n_q + res;
      MOP_V2F:  v2f_q <= v2n_q - res;
      MOP_O1X:  o1x_q <= res + t1x_q;
      MOP_O1Y:  o1y_q <= res + t1y_q;
      MOP_O2X:  o2x_q <= res + t2x_q;
      MOP_O2Y:  o2y_q <= res + t2y_q;
      default:  ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    case (cmd_i.emit)
      EMIT_PASS, EMIT_CUR: begin
        opx_q    <= cpx_q;
        opy_q    <= cpy_q;
        ovx_q    <= cvx_q;
        ovy_q    <= cvy_q;
        otouch_q <= 1'b0;
        olast_q  <= 1'b1;
      end
      EMIT_HELD: begin
        opx_q    <= hpx_q;
        opy_q    <= hpy_q;
        ovx_q    <= hvx_q;
        ovy_q    <= hvy_q;
        otouch_q <= 1'b0;
        olast_q  <= 1'b0;
      end
      EMIT_RES0: begin
        opx_q    <= sat32(40'(hpx_q) - ddx_q);
        opy_q    <= sat32(40'(hpy_q) - ddy_q);
        ovx_q    <= sat32(o1x_q);
        ovy_q    <= sat32(o1y_q);
        otouch_q <= 1'b1;
        olast_q  <= 1'b0;
      end
      EMIT_RES1: begin
        opx_q    <= sat32(40'(cpx_q) + ddx_q);
        opy_q    <= sat32(40'(cpy_q) + ddy_q);
        ovx_q    <= sat32(o2x_q);
        ovy_q    <= sat32(o2y_q);
        otouch_q <= 1'b1;
        olast_q  <= 1'b1;
      end
      default: ;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    sts_o.sqrt_done = sqrt_done;
    sts_o.div_done  = div_done;
    sts_o.no_hit    = (d == '0) || (d >= 33'(rsum));
  end

  assign pos_x_o   = opx_q;
  assign pos_y_o   = opy_q;
  assign vel_x_o   = ovx_q;
  assign vel_y_o   = ovy_q;
  assign touched_o = otouch_q;
  assign last_o    = olast_q;

endmodule

/* hdl/circle_collision_resolver_core.sv */
// ---------------------------------------------------------------------------
// circle_collision_resolver_core: two-circle collision response
// Holds the first particle of a pair and resolves the second against it.
// ---------------------------------------------------------------------------
// A first item (second_of_pair low) is stored and gives no result. A
// second item with no particle held is passed back unchanged as one
// result. Otherwise the block works through the square root of the
// squared distance, two normal divisions, two ratio divisions and some
// twenty passes through the single shared multiplier. Pairs without
// overlap leave after the square root. Input is stalled while a pair is
// in work; the output register lets a new pair start while the last
// result is still waiting to be transferred.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module circle_collision_resolver_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] in_pos_x_i,
  input  logic signed [31:0] in_pos_y_i,
  input  logic signed [31:0] in_vel_x_i,
  input  logic signed [31:0] in_vel_y_i,
  input  logic [30:0]        in_radius_i,
  input  logic [16:0]        in_elasticity_i,
  input  logic [30:0]        in_mass_i,
  input  logic               second_of_pair_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_vel_x_o,
  output logic signed [31:0] out_vel_y_o,
  output logic               touched_o,
  output logic               last_of_pair_o
);

  import ccr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ccr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .second_i    (second_of_pair_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ccr_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pos_x_i      (in_pos_x_i),
    .pos_y_i      (in_pos_y_i),
    .vel_x_i      (in_vel_x_i),
    .vel_y_i      (in_vel_y_i),
    .radius_i     (in_radius_i),
    .elasticity_i (in_elasticity_i),
    .mass_i       (in_mass_i),
    .pos_x_o      (out_pos_x_o),
    .pos_y_o      (out_pos_y_o),
    .vel_x_o      (out_vel_x_o),
    .vel_y_o      (out_vel_y_o),
    .touched_o    (touched_o),
    .last_o       (last_of_pair_o)
  );

  // A second item always starts work, so the input stalls right after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && second_of_pair_i) |=> in_stall_o)
    else $error("input not stalled after a second item");

  // The output register is only loaded when its slot is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit != EMIT_NONE) |-> (!out_valid_o || !out_stall_i))
    else $error("result loaded over a pending transfer");

  // The square root and the divider never finish in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sts.sqrt_done && sts.div_done))
    else $error("square root and divider finished together");

endmodule

/* sim/ccr_response_checker.sv */
// ---------------------------------------------------------------------------
// ccr_response_checker: result predictor and scoreboard
// Watches both channels of the circle collision resolver, computes the
// expected results of every accepted input transfer and compares each
// output transfer field by field with the oldest expected result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_response_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] in_pos_x_i,
  input  logic signed [31:0] in_pos_y_i,
  input  logic signed [31:0] in_vel_x_i,
  input  logic signed [31:0] in_vel_y_i,
  input  logic [30:0]        in_radius_i,
  input  logic [16:0]        in_elasticity_i,
  input  logic [30:0]        in_mass_i,
  input  logic               second_of_pair_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] out_pos_x_i,
  input  logic signed [31:0] out_pos_y_i,
  input  logic signed [31:0] out_vel_x_i,
  input  logic signed [31:0] out_vel_y_i,
  input  logic               touched_i,
  input  logic               last_of_pair_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  import ccr_pkg::*;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               touched;
    logic               last;
  } particle_out_t;

  particle_out_t resolved_q[$];

  // Particle waiting for its partner.
  longint            held_px, held_py, held_vx, held_vy;
  longint unsigned   held_rad, held_elas, held_mass;
  logic              holding;

  // Product shifted right, truncated toward zero, with 64-bit wrap.
  function automatic longint scale_mul(input longint a, input longint b, input int sh);
    longint unsigned ma, mb, p;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    p  = (ma * mb) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Floor square root of a 66-bit value.
  function automatic longint unsigned floor_root(input logic [65:0] sq);
    longint unsigned root, rem, trial;
    root = 0;
    rem  = 0;
    for (int i = 32; i >= 0; i--) begin
      rem   = (rem << 2) | 64'(sq[2*i +: 2]);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic particle_out_t make_out(input longint px, input longint py,
                                             input longint vx, input longint vy,
                                             input logic t, input logic l);
    particle_out_t o;
    o.pos_x   = clamp32(px);
    o.pos_y   = clamp32(py);
    o.vel_x   = clamp32(vx);
    o.vel_y   = clamp32(vy);
    o.touched = t;
    o.last    = l;
    return o;
  endfunction

  // Resolve the second particle against the held one and queue both results.
  task automatic resolve_pair(input longint px, input longint py, input longint vx,
                              input longint vy, input longint unsigned rad,
                              input longint unsigned elas, input longint unsigned mass);
    longint dx, dy, nx, ny, half, ddx, ddy, v1n, v2n, t1x, t1y, t2x, t2y, w, v1f, v2f;
    longint unsigned ax, ay, sx2, sy2, lo, d, rsum, ee, m1, m2, msum, k, r1, r2;
    logic [65:0] sq;
    dx   = px - held_px;
    dy   = py - held_py;
    ax   = (dx < 0) ? 64'(-dx) : 64'(dx);
    ay   = (dy < 0) ? 64'(-dy) : 64'(dy);
    sx2  = ax * ax;
    sy2  = ay * ay;
    lo   = sx2 + sy2;
    sq   = {1'b0, (lo < sy2), lo};
    d    = floor_root(sq);
    rsum = held_rad + rad;
    if (d == 0 || d >= rsum) begin
      resolved_q.push_back(make_out(held_px, held_py, held_vx, held_vy, 1'b0, 1'b0));
      resolved_q.push_back(make_out(px, py, vx, vy, 1'b0, 1'b1));
      return;
    end
    nx = longint'((ax << FRAC_BITS) / d);
    ny = longint'((ay << FRAC_BITS) / d);
    if (dx < 0) nx = -nx;
    if (dy < 0) ny = -ny;
    half = longint'((rsum - d) >> 1);
    ddx  = scale_mul(nx, half, FRAC_BITS);
    ddy  = scale_mul(ny, half, FRAC_BITS);
    v1n  = scale_mul(held_vx, nx, FRAC_BITS) + scale_mul(held_vy, ny, FRAC_BITS);
    v2n  = scale_mul(vx, nx, FRAC_BITS) + scale_mul(vy, ny, FRAC_BITS);
    t1x  = held_vx - scale_mul(v1n, nx, FRAC_BITS);
    t1y  = held_vy - scale_mul(v1n, ny, FRAC_BITS);
    t2x  = vx - scale_mul(v2n, nx, FRAC_BITS);
    t2y  = vy - scale_mul(v2n, ny, FRAC_BITS);
    // Restitution is the smaller elasticity, capped at one.
    ee = (held_elas < elas) ? held_elas : elas;
    if (ee > 64'(ELAS_ONE)) ee = 64'(ELAS_ONE);
    m1   = held_mass;
    m2   = mass;
    msum = m1 + m2;
    if (msum == 0) begin
      m1   = 1;
      m2   = 1;
      msum = 2;
    end
    k   = (64'(ELAS_ONE) + ee) << (RATIO_BITS - 16);
    r2  = (m2 * k) / msum;
    r1  = (m1 * k) / msum;
    w   = v2n - v1n;
    v1f = v1n + scale_mul(w, longint'(r2), RATIO_BITS);
    v2f = v2n - scale_mul(w, longint'(r1), RATIO_BITS);
    resolved_q.push_back(make_out(held_px - ddx, held_py - ddy,
                                  scale_mul(v1f, nx, FRAC_BITS) + t1x,
                                  scale_mul(v1f, ny, FRAC_BITS) + t1y, 1'b1, 1'b0));
    resolved_q.push_back(make_out(px + ddx, py + ddy,
                                  scale_mul(v2f, nx, FRAC_BITS) + t2x,
                                  scale_mul(v2f, ny, FRAC_BITS) + t2y, 1'b1, 1'b1));
  endtask

  // Compare output transfers, then predict from input transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    particle_out_t seen, want;
    if (!rst_ni) begin
      resolved_q.delete();
      held_px      = 0;
      held_py      = 0;
      held_vx      = 0;
      held_vy      = 0;
      held_rad     = 0;
      held_elas    = 0;
      held_mass    = 0;
      holding      = 1'b0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen = '{out_pos_x_i, out_pos_y_i, out_vel_x_i, out_vel_y_i, touched_i,
                 last_of_pair_i};
        if (resolved_q.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: unexpected result %h", $realtime, seen);
          end
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = resolved_q.pop_front();
          if (seen !== want) begin
            if (fail_count_o < 10) begin
              $display("%0t: mismatch expected px %h py %h vx %h vy %h t %b l %b",
                       $realtime, want.pos_x, want.pos_y, want.vel_x, want.vel_y,
                       want.touched, want.last);
              $display("%0t:            actual px %h py %h vx %h vy %h t %b l %b",
                       $realtime, seen.pos_x, seen.pos_y, seen.vel_x, seen.vel_y,
                       seen.touched, seen.last);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (!second_of_pair_i) begin
          held_px   = in_pos_x_i;
          held_py   = in_pos_y_i;
          held_vx   = in_vel_x_i;
          held_vy   = in_vel_y_i;
          held_rad  = in_radius_i;
          held_elas = in_elasticity_i;
          held_mass = in_mass_i;
          holding   = 1'b1;
        end else if (!holding) begin
          resolved_q.push_back(make_out(in_pos_x_i, in_pos_y_i, in_vel_x_i, in_vel_y_i,
                                        1'b0, 1'b1));
        end else begin
          holding = 1'b0;
          resolve_pair(in_pos_x_i, in_pos_y_i, in_vel_x_i, in_vel_y_i, in_radius_i,
                       in_elasticity_i, in_mass_i);
        end
      end
      pending_o <= resolved_q.size();
    end
  end

endmodule

/* sim/circle_collision_resolver_core_test.sv */
// ---------------------------------------------------------------------------
// circle_collision_resolver_core_test: testbench top of the collision resolver
// Drives directed and random particle pairs with random sender gaps and
// receiver stalls; the response checker beside the block does the prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module circle_collision_resolver_core_test;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] in_pos_x_i = '0;
  logic signed [31:0] in_pos_y_i = '0;
  logic signed [31:0] in_vel_x_i = '0;
  logic signed [31:0] in_vel_y_i = '0;
  logic [30:0]        in_radius_i = '0;
  logic [16:0]        in_elasticity_i = '0;
  logic [30:0]        in_mass_i = '0;
  logic               second_of_pair_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] out_pos_x_o, out_pos_y_o, out_vel_x_o, out_vel_y_o;
  logic               touched_o, last_of_pair_o;
  int                 fail_count, pending;
  int                 send_gap_pct = 0;
  int                 recv_stall_pct = 0;
  int                 sent = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  circle_collision_resolver_core dut (.*);

  ccr_response_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_pos_x_i, .in_pos_y_i,
    .in_vel_x_i, .in_vel_y_i, .in_radius_i, .in_elasticity_i, .in_mass_i,
    .second_of_pair_i, .out_valid_i(out_valid_o), .out_stall_i, .out_pos_x_i(out_pos_x_o),
    .out_pos_y_i(out_pos_y_o), .out_vel_x_i(out_vel_x_o), .out_vel_y_i(out_vel_y_o),
    .touched_i(touched_o), .last_of_pair_i(last_of_pair_o), .fail_count_o(fail_count),
    .pending_o(pending)
  );

  // Receiver stalls at random.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // One input transfer, with a random gap in front of it.
  task automatic send_particle(input logic [31:0] px, input logic [31:0] py,
                               input logic [31:0] vx, input logic [31:0] vy,
                               input logic [30:0] rad, input logic [16:0] elas,
                               input logic [30:0] mass, input logic second);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_pos_x_i       <= px;
    in_pos_y_i       <= py;
    in_vel_x_i       <= vx;
    in_vel_y_i       <= vy;
    in_radius_i      <= rad;
    in_elasticity_i  <= elas;
    in_mass_i        <= mass;
    second_of_pair_i <= second;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    sent++;
  endtask

  // Hold off until every expected result has been transferred.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(3))
      0:       return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic logic [16:0] rand_elas();
    return ($urandom_range(9) == 0) ? 17'($urandom_range(0, 131071))
                                    : 17'($urandom_range(0, 65536));
  endfunction

  function automatic logic [30:0] rand_mass();
    return ($urandom_range(3) == 0) ? 31'($urandom_range(1, 32'h7fffffff))
                                    : 31'($urandom_range(1, 1 << 20));
  endfunction

  // Mostly close pairs with random content, the rest noise.
  task automatic random_traffic(input int count);
    logic [31:0] bx, by;
    int          lim, spread;
    for (int n = 0; n < count; n += 2) begin
      if ($urandom_range(99) < 78) begin
        spread = 1 << $urandom_range(4, 22);
        bx     = $urandom;
        by     = $urandom;
        if ($urandom_range(1)) begin
          bx = 32'($signed(bx) >>> 3);
          by = 32'($signed(by) >>> 3);
        end
        lim = spread;
        send_particle(bx, by, rand_vel(), rand_vel(), 31'($urandom_range(0, lim)),
                      rand_elas(), rand_mass(), 1'b0);
        send_particle(bx + 32'($urandom_range(0, spread)) - 32'(spread / 2),
                      by + 32'($urandom_range(0, spread)) - 32'(spread / 2),
                      rand_vel(), rand_vel(), 31'($urandom_range(0, lim)),
                      rand_elas(), rand_mass(), 1'b1);
      end else begin
        send_particle($urandom, $urandom, $urandom, $urandom, 31'($urandom),
                      17'($urandom), 31'($urandom), 1'($urandom));
        send_particle($urandom, $urandom, $urandom, $urandom, 31'($urandom),
                      17'($urandom), 31'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: lone second, repeated first, zero distance, no contact,
    // deep overlap, extremes, elasticity above one and zero masses.
    send_particle(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  31'h7fffffff, 17'h1ffff, 31'h7fffffff, 1'b1);
    send_particle(32'd100, 32'd200, 32'd5, 32'd6, 31'd10, 17'd0, 31'd1, 1'b0);
    send_particle(32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0, 31'h0001_0000,
                  17'd65536, 31'h0001_0000, 1'b0);
    send_particle(32'h0001_8000, 32'h0, 32'hfffe_0000, 32'h0, 31'h0001_0000,
                  17'd65536, 31'h0001_0000, 1'b1);
    send_particle(32'h1234, 32'h5678, 32'h1, 32'h2, 31'h7fffffff, 17'h1ffff,
                  31'd5, 1'b0);
    send_particle(32'h1234, 32'h5678, 32'h3, 32'h4, 31'h7fffffff, 17'h1ffff,
                  31'd7, 1'b1);
    send_particle(32'h0, 32'h0, 32'h0, 32'h0, 31'd3, 17'd0, 31'd1, 1'b0);
    send_particle(32'd6, 32'd0, 32'h0, 32'h0, 31'd3, 17'd0, 31'd1, 1'b1);
    send_particle(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                  31'h7fffffff, 17'h1ffff, 31'h7fffffff, 1'b0);
    send_particle(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                  31'h7fffffff, 17'h1ffff, 31'h7fffffff, 1'b1);
    send_particle(32'h0, 32'h0, 32'h0003_0000, 32'hffff_0000, 31'h0004_0000,
                  17'h1ffff, 31'd0, 1'b0);
    send_particle(32'h0002_0000, 32'h0001_0000, 32'hfffd_0000, 32'h0001_0000,
                  31'h0004_0000, 17'h1ffff, 31'd0, 1'b1);
    send_particle(32'hffff_0000, 32'h0, 32'h0, 32'h0, 31'h0002_0000, 17'd30000,
                  31'h7fffffff, 1'b0);
    send_particle(32'h0000_1000, 32'hffff_f000, 32'h0, 32'h0, 31'h0002_0000,
                  17'd0, 31'd1, 1'b1);
    send_particle(32'h0, 32'h0, 32'h0, 32'h0, 31'd0, 17'd0, 31'd1, 1'b1);
    drain_results();

    send_gap_pct   = 37;
    recv_stall_pct = 77;
    random_traffic(566);
    drain_results();
    send_gap_pct   = 77;
    recv_stall_pct = 37;
    random_traffic(566);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    random_traffic(566);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
hdl/ccr_pkg.sv
hdl/ccr_sqrt.sv
hdl/ccr_divider.sv
hdl/ccr_ctrl.sv
hdl/ccr_datapath.sv
hdl/circle_collision_resolver_core.sv
sim/ccr_response_checker.sv
sim/circle_collision_resolver_core_test.sv
